// ===== hw/rtl/vbost_pkg.sv =====
`default_nettype none
package vbost_pkg;

  localparam int unsigned VOXELS_DEF = 65536;
  localparam int unsigned SPLIT_ENTRIES_DEF = 64;
  localparam logic [7:0] ALL_ONES = 8'hFF;

  localparam logic [2:0] ACT_SET_VOXEL = 3'd0;
  localparam logic [2:0] ACT_GET_VOXEL = 3'd1;
  localparam logic [2:0] ACT_SET_OCT = 3'd2;
  localparam logic [2:0] ACT_GET_OCT = 3'd3;
  localparam logic [2:0] ACT_OPTIMIZE = 3'd4;
  localparam logic [2:0] ACT_CLEAR = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_IDX2,
    CMD_SCAN,
    CMD_BITRD,
    CMD_EXEC,
    CMD_OPT_RD,
    CMD_OPT_WR,
    CMD_CLR,
    CMD_FINISH
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic range_bad;
    logic scan_done;
    logic opt_done;
    logic clr_done;
  } status_t;

  function automatic logic [7:0] octant_bit(input logic [2:0] o);
    logic [7:0] r;
    r = 8'd1 << o;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vbost_datapath.sv =====
`default_nettype none
module vbost_datapath #(
  parameter int unsigned VOXELS = vbost_pkg::VOXELS_DEF,
  parameter int unsigned SPLIT_ENTRIES = vbost_pkg::SPLIT_ENTRIES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire vbost_pkg::cmd_t cmd,
  output vbost_pkg::status_t stat,
  input  wire logic cfg_valid,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data,
  input  wire logic [2:0] action,
  input  wire logic [7:0] coord_x,
  input  wire logic [7:0] coord_y,
  input  wire logic [7:0] coord_z,
  input  wire logic [2:0] octant,
  input  wire logic bit_value,
  output logic res_read_bit,
  output logic res_is_split,
  output logic [1:0] res_status
);
  localparam int unsigned VW = $clog2(VOXELS);
  localparam int unsigned EW = (SPLIT_ENTRIES > 1) ? $clog2(SPLIT_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(SPLIT_ENTRIES + 1);

  logic [8:0] size_x, size_y, size_z;
  logic [2:0] act;
  logic [7:0] cz;
  logic [2:0] oct;
  logic val;
  logic range_bad;
  logic [17:0] pxy;
  logic [25:0] lin;
  logic [25:0] lin_full;
  logic [VW-1:0] idx;

  logic bits_mem [VOXELS];
  logic bits_rd;
  logic [VW-1:0] clr_addr;
  logic clr_done;

  logic [SPLIT_ENTRIES-1:0] split_valid;
  logic [VW-1:0] split_index [SPLIT_ENTRIES];
  logic [7:0] split_mask [SPLIT_ENTRIES];
  logic [VW-1:0] rd_index;
  logic [7:0] rd_mask;
  logic [EW-1:0] rd_e;
  logic scan_live, opt_live;

  logic [CW-1:0] scan;
  logic hit, have_free;
  logic [EW-1:0] hit_e, free_e;
  logic [7:0] hit_mask;
  logic opt_fold;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= 9'd16;
      size_y <= 9'd16;
      size_z <= 9'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        vbost_pkg::REG_SIZE_X: size_x <= cfg_data;
        vbost_pkg::REG_SIZE_Y: size_y <= cfg_data;
        vbost_pkg::REG_SIZE_Z: size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign lin_full = lin + 26'(pxy) * 26'(cz);

  always_ff @(posedge clk) begin
    if (cmd == vbost_pkg::CMD_LATCH) begin
      act <= action;
      cz <= coord_z;
      oct <= octant;
      val <= bit_value;
      range_bad <= ({1'b0, coord_x} >= size_x) || ({1'b0, coord_y} >= size_y)
                   || ({1'b0, coord_z} >= size_z);
      pxy <= 18'(size_x) * 18'(size_y);
      lin <= {18'd0, coord_x} + {8'd0, 18'(size_x) * 18'({1'b0, coord_y})};
    end
    if (cmd == vbost_pkg::CMD_IDX2) begin
      lin <= lin_full;
      if (lin_full >= 26'(VOXELS)) range_bad <= 1'b1;
    end
  end
  assign idx = lin[VW-1:0];

  always_comb begin
    stat.action = act;
    stat.range_bad = range_bad;
    stat.scan_done = (scan == CW'(SPLIT_ENTRIES));
    stat.opt_done = (scan == CW'(SPLIT_ENTRIES));
    stat.clr_done = clr_done;
  end

  // table data arrives the cycle after its read address
  assign opt_fold = opt_live && split_valid[rd_e] &&
    (rd_mask == 8'd0 || rd_mask == vbost_pkg::ALL_ONES);

  always_ff @(posedge clk) begin
    if (rst) begin
      split_valid <= '0;
      scan <= '0;
      clr_addr <= '0;
      clr_done <= 1'b0;
      scan_live <= 1'b0;
      opt_live <= 1'b0;
    end else begin
      scan_live <= (cmd == vbost_pkg::CMD_SCAN);
      opt_live <= (cmd == vbost_pkg::CMD_OPT_RD);
      if (scan_live) begin
        if (split_valid[rd_e] && rd_index == idx && !hit) begin
          hit <= 1'b1;
          hit_e <= rd_e;
          hit_mask <= rd_mask;
        end
        if (!split_valid[rd_e] && !have_free) begin
          have_free <= 1'b1;
          free_e <= rd_e;
        end
      end
      if (opt_fold) split_valid[rd_e] <= 1'b0;
      case (cmd)
        vbost_pkg::CMD_IDX2: begin
          scan <= '0;
          hit <= 1'b0;
          have_free <= 1'b0;
          clr_addr <= '0;
          clr_done <= 1'b0;
        end
        vbost_pkg::CMD_SCAN: begin
          scan <= scan + 1'b1;
        end
        vbost_pkg::CMD_OPT_RD: begin
          scan <= scan + 1'b1;
        end
        vbost_pkg::CMD_CLR: begin
          split_valid <= '0;
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == VW'(VOXELS - 1)) clr_done <= 1'b1;
        end
        vbost_pkg::CMD_EXEC: begin
          if (act == vbost_pkg::ACT_SET_VOXEL && hit) split_valid[hit_e] <= 1'b0;
          if (act == vbost_pkg::ACT_SET_OCT && !hit && have_free)
            split_valid[free_e] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == vbost_pkg::CMD_EXEC && act == vbost_pkg::ACT_SET_OCT) begin
      if (hit) begin
        split_mask[hit_e] <= val ? (hit_mask | vbost_pkg::octant_bit(oct))
                                 : (hit_mask & ~vbost_pkg::octant_bit(oct));
      end else if (have_free) begin
        split_index[free_e] <= idx;
        split_mask[free_e] <= val ? vbost_pkg::octant_bit(oct) : 8'd0;
      end
    end
    rd_index <= split_index[scan[EW-1:0]];
    rd_mask <= split_mask[scan[EW-1:0]];
    rd_e <= scan[EW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd == vbost_pkg::CMD_CLR)
      bits_mem[clr_addr] <= 1'b0;
    else if (opt_fold)
      bits_mem[rd_index] <= (rd_mask != 8'd0);
    else if (cmd == vbost_pkg::CMD_EXEC && act == vbost_pkg::ACT_SET_VOXEL)
      bits_mem[idx] <= val;
    bits_rd <= bits_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd == vbost_pkg::CMD_FINISH) begin
      res_read_bit <= 1'b0;
      res_is_split <= 1'b0;
      res_status <= vbost_pkg::ST_OK;
      if (act > vbost_pkg::ACT_CLEAR ||
          (act < vbost_pkg::ACT_OPTIMIZE && range_bad)) begin
        res_status <= vbost_pkg::ST_RANGE;
      end else begin
        case (act)
          vbost_pkg::ACT_GET_VOXEL: begin
            res_read_bit <= bits_rd;
            res_is_split <= hit;
          end
          vbost_pkg::ACT_SET_OCT: begin
            if (!hit && !have_free) res_status <= vbost_pkg::ST_FULL;
            else res_is_split <= 1'b1;
          end
          vbost_pkg::ACT_GET_OCT: begin
            res_read_bit <= hit ? |(hit_mask & vbost_pkg::octant_bit(oct)) : bits_rd;
            res_is_split <= hit;
          end
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/vbost_ctrl.sv =====
`default_nettype none
module vbost_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  output vbost_pkg::cmd_t cmd,
  input  wire vbost_pkg::status_t stat
);
  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_IDX, S_SCAN, S_RD, S_EXEC, S_OPT, S_OPTW, S_CLR, S_FIN, S_OUT
  } state_t;
  state_t state;

  always_comb begin
    in_ready = (state == S_IDLE);
    out_valid = (state == S_OUT);
    case (state)
      S_INIT: cmd = stat.clr_done ? vbost_pkg::CMD_NONE : vbost_pkg::CMD_CLR;
      S_IDLE: cmd = in_valid ? vbost_pkg::CMD_LATCH : vbost_pkg::CMD_NONE;
      S_IDX: cmd = vbost_pkg::CMD_IDX2;
      S_SCAN: cmd = stat.scan_done ? vbost_pkg::CMD_NONE : vbost_pkg::CMD_SCAN;
      S_RD: cmd = vbost_pkg::CMD_BITRD;
      S_EXEC: cmd = vbost_pkg::CMD_EXEC;
      S_OPT: cmd = stat.opt_done ? vbost_pkg::CMD_NONE : vbost_pkg::CMD_OPT_RD;
      S_OPTW: cmd = vbost_pkg::CMD_NONE;
      S_CLR: cmd = stat.clr_done ? vbost_pkg::CMD_NONE : vbost_pkg::CMD_CLR;
      S_FIN: cmd = vbost_pkg::CMD_FINISH;
      default: cmd = vbost_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      case (state)
        S_INIT: if (stat.clr_done) state <= S_IDLE;
        S_IDLE: if (in_valid) state <= S_IDX;
        S_IDX: begin
          if (stat.action == vbost_pkg::ACT_OPTIMIZE) state <= S_OPT;
          else if (stat.action == vbost_pkg::ACT_CLEAR) state <= S_CLR;
          else state <= S_SCAN;
        end
        S_SCAN: begin
          if (stat.scan_done) state <= stat.range_bad ? S_FIN : S_RD;
        end
        S_RD: state <= (stat.action > vbost_pkg::ACT_CLEAR) ? S_FIN : S_EXEC;
        S_EXEC: state <= S_FIN;
        S_OPT: if (stat.opt_done) state <= S_OPTW;
        S_OPTW: state <= S_FIN;
        S_CLR: if (stat.clr_done) state <= S_FIN;
        S_FIN: state <= S_OUT;
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/voxel_bitmap_with_octant_split_table_unit.sv =====
`default_nettype none
// channel | signals                                           | dir
// cfg     | cfg_valid cfg_ready cfg_index cfg_data            | in
// in      | in_valid in_ready action coord_* octant bit_value | in
// out     | out_valid out_ready read_bit is_split status      | out
// After reset the bitmap is cleared one bit per cycle; in_ready rises once clearing is done.
// Voxel actions: serial table scan, then bit read, execute and finish; a coordinate range
// error skips the bit read and execute steps. A new item is taken only after the result.
// Optimize: one table entry per cycle.
// Clear: one bitmap bit cleared per cycle.
// Synchronous reset. A stalled result holds input off.
module voxel_bitmap_with_octant_split_table_unit #(
  parameter int unsigned VOXELS = vbost_pkg::VOXELS_DEF,
  parameter int unsigned SPLIT_ENTRIES = vbost_pkg::SPLIT_ENTRIES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [2:0] action,
  input  wire logic [7:0] coord_x,
  input  wire logic [7:0] coord_y,
  input  wire logic [7:0] coord_z,
  input  wire logic [2:0] octant,
  input  wire logic bit_value,
  output logic out_valid,
  input  wire logic out_ready,
  output logic read_bit,
  output logic is_split,
  output logic [1:0] status
);
  vbost_pkg::cmd_t cmd;
  vbost_pkg::status_t stat;

  assign cfg_ready = 1'b1;

  vbost_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
  );

  vbost_datapath #(.VOXELS(VOXELS), .SPLIT_ENTRIES(SPLIT_ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .action(action), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .octant(octant), .bit_value(bit_value),
    .res_read_bit(read_bit), .res_is_split(is_split), .res_status(status)
  );
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
module tb;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;
  logic in_valid, in_ready;
  logic [2:0] action;
  logic [7:0] coord_x, coord_y, coord_z;
  logic [2:0] octant;
  logic bit_value;
  logic out_valid, out_ready;
  logic read_bit, is_split;
  logic [1:0] status;

  voxel_bitmap_with_octant_split_table_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .octant(octant), .bit_value(bit_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_bit(read_bit), .is_split(is_split), .status(status)
  );

  typedef struct {
    logic rd;
    logic sp;
    logic [1:0] st;
  } voxel_resp_t;

  class voxel_scoreboard;
    bit bitmap [vbost_pkg::VOXELS_DEF];
    bit ent_valid [vbost_pkg::SPLIT_ENTRIES_DEF];
    logic [15:0] ent_index [vbost_pkg::SPLIT_ENTRIES_DEF];
    logic [7:0] ent_mask [vbost_pkg::SPLIT_ENTRIES_DEF];
    logic [8:0] size_x, size_y, size_z;
    voxel_resp_t pending[$];
    int errors, n_in, n_out, n_full, n_range, n_split_rd;

    function new();
      size_x = 16;
      size_y = 16;
      size_z = 16;
      for (int i = 0; i < vbost_pkg::SPLIT_ENTRIES_DEF; i++) ent_valid[i] = 0;
      for (int i = 0; i < vbost_pkg::VOXELS_DEF; i++) bitmap[i] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [8:0] v);
      if (idx == vbost_pkg::REG_SIZE_X) size_x = v;
      else if (idx == vbost_pkg::REG_SIZE_Y) size_y = v;
      else if (idx == vbost_pkg::REG_SIZE_Z) size_z = v;
    endfunction

    function int lookup(int unsigned idx);
      for (int i = 0; i < vbost_pkg::SPLIT_ENTRIES_DEF; i++)
        if (ent_valid[i] && ent_index[i] == idx) return i;
      return -1;
    endfunction

    function void note_input(logic [2:0] a, logic [7:0] x, logic [7:0] y, logic [7:0] z,
                             logic [2:0] o, logic b);
      voxel_resp_t r;
      longint unsigned lin;
      int e;
      r.rd = 0;
      r.sp = 0;
      r.st = vbost_pkg::ST_OK;
      n_in++;
      if (a == vbost_pkg::ACT_OPTIMIZE) begin
        for (int i = 0; i < vbost_pkg::SPLIT_ENTRIES_DEF; i++)
          if (ent_valid[i] && (ent_mask[i] == 8'h00 || ent_mask[i] == vbost_pkg::ALL_ONES)) begin
            bitmap[ent_index[i]] = (ent_mask[i] != 8'h00);
            ent_valid[i] = 0;
          end
      end else if (a == vbost_pkg::ACT_CLEAR) begin
        for (int i = 0; i < vbost_pkg::VOXELS_DEF; i++) bitmap[i] = 0;
        for (int i = 0; i < vbost_pkg::SPLIT_ENTRIES_DEF; i++) ent_valid[i] = 0;
      end else if (a > vbost_pkg::ACT_CLEAR) begin
        r.st = vbost_pkg::ST_RANGE;
      end else begin
        lin = longint'(x) + longint'(size_x) * y + longint'(size_x) * size_y * z;
        if (x >= size_x || y >= size_y || z >= size_z || lin >= vbost_pkg::VOXELS_DEF) begin
          r.st = vbost_pkg::ST_RANGE;
        end else begin
          e = lookup(lin[31:0]);
          case (a)
            vbost_pkg::ACT_SET_VOXEL: begin
              if (e >= 0) ent_valid[e] = 0;
              bitmap[lin] = b;
            end
            vbost_pkg::ACT_GET_VOXEL: begin
              r.rd = bitmap[lin];
              r.sp = (e >= 0);
            end
            vbost_pkg::ACT_SET_OCT: begin
              if (e < 0) begin
                for (int i = 0; i < vbost_pkg::SPLIT_ENTRIES_DEF; i++)
                  if (!ent_valid[i]) begin
                    e = i;
                    break;
                  end
                if (e >= 0) begin
                  ent_valid[e] = 1;
                  ent_index[e] = lin[15:0];
                  ent_mask[e] = 8'h00;
                end
              end
              if (e < 0) begin
                r.st = vbost_pkg::ST_FULL;
              end else begin
                ent_mask[e][o] = b;
                r.sp = 1;
              end
            end
            default: begin
              if (e >= 0) begin
                r.rd = ent_mask[e][o];
                r.sp = 1;
                n_split_rd++;
              end else begin
                r.rd = bitmap[lin];
              end
            end
          endcase
        end
      end
      if (r.st == vbost_pkg::ST_FULL) n_full++;
      if (r.st == vbost_pkg::ST_RANGE) n_range++;
      pending.push_back(r);
    endfunction

    function void check_result(logic rd, logic sp, logic [1:0] st);
      voxel_resp_t w;
      n_out++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result rd=%b split=%b status=%0d", $time, rd, sp, st);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (rd !== w.rd) begin
        $display("%0t: read_bit expected %b actual %b", $time, w.rd, rd);
        errors++;
      end
      if (sp !== w.sp) begin
        $display("%0t: is_split expected %b actual %b", $time, w.sp, sp);
        errors++;
      end
      if (st !== w.st) begin
        $display("%0t: status expected %0d actual %0d", $time, w.st, st);
        errors++;
      end
    endfunction
  endclass

  voxel_scoreboard sb;
  bit quiet;
  int clears_left;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #24000000;
    $display("FAILURE");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(read_bit, is_split, status);
  end

  initial begin
    int g;
    out_ready = 0;
    @(negedge rst);
    forever begin
      g = pick_gap();
      if (g > 0) begin
        out_ready <= 0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic send(logic [2:0] a, logic [7:0] x, logic [7:0] y, logic [7:0] z,
                      logic [2:0] o, logic b);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    action <= a;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    octant <= o;
    bit_value <= b;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(a, x, y, z, o, b);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_sizes(logic [8:0] sx, logic [8:0] sy, logic [8:0] sz);
    logic [8:0] v [3];
    v[0] = sx;
    v[1] = sy;
    v[2] = sz;
    drain();
    for (int i = 0; i < 3; i++) begin
      cfg_index <= i[1:0];
      cfg_data <= v[i];
      cfg_valid <= 1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_reg(i[1:0], v[i]);
    end
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_coord(logic [8:0] sz);
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, sz - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_phase(int count, bit fill);
    int r, done;
    logic [2:0] a;
    logic [7:0] x, y, z;
    logic b;
    done = 0;
    while (done < count) begin
      x = pick_coord(sb.size_x);
      y = pick_coord(sb.size_y);
      z = pick_coord(sb.size_z);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // whole voxel through its octants, then fold unless filling
        b = 1'($urandom_range(0, 1));
        for (int o = 0; o < 8; o++) send(vbost_pkg::ACT_SET_OCT, x, y, z, o[2:0], b);
        send(vbost_pkg::ACT_GET_OCT, x, y, z, 3'($urandom_range(0, 7)), 1'b0);
        if (!fill) send(vbost_pkg::ACT_OPTIMIZE, 0, 0, 0, 0, 0);
        send(vbost_pkg::ACT_GET_VOXEL, x, y, z, 0, 0);
        done += 11;
        continue;
      end
      r = $urandom_range(0, 99);
      if (fill) a = (r < 75) ? vbost_pkg::ACT_SET_OCT :
                    (r < 90) ? vbost_pkg::ACT_GET_OCT : vbost_pkg::ACT_GET_VOXEL;
      else if (r < 15) a = vbost_pkg::ACT_SET_VOXEL;
      else if (r < 30) a = vbost_pkg::ACT_GET_VOXEL;
      else if (r < 60) a = vbost_pkg::ACT_SET_OCT;
      else if (r < 85) a = vbost_pkg::ACT_GET_OCT;
      else if (r < 94) a = vbost_pkg::ACT_OPTIMIZE;
      else if (r < 96 && clears_left > 0) begin
        a = vbost_pkg::ACT_CLEAR;
        clears_left--;
      end else a = 3'($urandom_range(6, 7));
      send(a, x, y, z, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      done++;
    end
  endtask

  initial begin
    sb = new();
    clears_left = 3;
    quiet = 0;
    rst = 1;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    in_valid = 0;
    action = 0;
    coord_x = 0;
    coord_y = 0;
    coord_z = 0;
    octant = 0;
    bit_value = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(vbost_pkg::ACT_SET_VOXEL, 0, 0, 0, 0, 1);
    send(vbost_pkg::ACT_GET_VOXEL, 0, 0, 0, 0, 0);
    send(vbost_pkg::ACT_SET_VOXEL, 15, 15, 15, 7, 1);
    send(vbost_pkg::ACT_GET_OCT, 15, 15, 15, 7, 0);
    send(vbost_pkg::ACT_GET_VOXEL, 16, 0, 0, 0, 0);
    send(vbost_pkg::ACT_SET_OCT, 0, 0, 255, 0, 1);
    send(vbost_pkg::ACT_SET_OCT, 1, 2, 3, 0, 1);
    send(vbost_pkg::ACT_SET_OCT, 1, 2, 3, 7, 1);
    send(vbost_pkg::ACT_GET_OCT, 1, 2, 3, 7, 0);
    send(vbost_pkg::ACT_GET_OCT, 1, 2, 3, 1, 0);
    send(vbost_pkg::ACT_GET_VOXEL, 1, 2, 3, 0, 0);
    send(vbost_pkg::ACT_SET_VOXEL, 1, 2, 3, 0, 0);
    send(vbost_pkg::ACT_GET_OCT, 1, 2, 3, 0, 0);
    send(vbost_pkg::ACT_SET_OCT, 2, 2, 2, 4, 0);
    for (int o = 0; o < 8; o++) send(vbost_pkg::ACT_SET_OCT, 3, 3, 3, o[2:0], 1);
    send(vbost_pkg::ACT_OPTIMIZE, 0, 0, 0, 0, 0);
    send(vbost_pkg::ACT_GET_VOXEL, 3, 3, 3, 0, 0);
    send(3'd6, 0, 0, 0, 0, 0);
    send(3'd7, 255, 255, 255, 7, 1);
    send(vbost_pkg::ACT_CLEAR, 0, 0, 0, 0, 0);
    send(vbost_pkg::ACT_GET_VOXEL, 0, 0, 0, 0, 0);

    random_phase(60, 0);
    write_sizes(1, 1, 1);
    random_phase(40, 0);
    quiet = 1;
    write_sizes(256, 256, 256);
    random_phase(90, 0);
    quiet = 0;
    write_sizes(8, 8, 4);
    random_phase(120, 1);
    random_phase(30, 0);
    write_sizes(256, 256, 1);
    random_phase(90, 0);
    write_sizes(3, 5, 7);
    random_phase(80, 0);
    drain();
    cfg_index <= 2'd3;
    cfg_data <= 9'h1FF;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    write_sizes(256, 1, 256);
    random_phase(90, 0);

    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d transfers in, %0d results out over seven size settings.",
             sb.n_in, sb.n_out);
    $display("Range errors %0d, table-full %0d, split octant reads %0d.",
             sb.n_range, sb.n_full, sb.n_split_rd);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
